[hdl/sts_pkg.sv]
// Shared types and constants for the two-key record sorter.
package sts_pkg;

	// Field widths of one stored record.
	localparam int IDX_W = 6;
	localparam int KEY_W = 8;

	// One record as it moves along the cell chain.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] len;
		logic [KEY_W-1:0] vow;
	} rec_t;

	// Commands broadcast from the controller to every cell.
	typedef struct packed {
		logic load;
		logic drain;
	} cell_ctrl_t;

	// Controller states: collecting records or draining the sorted run.
	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

endpackage

[hdl/sts_cell.sv]
// One cell of the insertion chain: holds one record in sorted position.
module sts_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sts_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  sts_pkg::rec_t      new_rec,
	input  logic               prev_win,
	input  sts_pkg::rec_t      prev_rec,
	input  sts_pkg::rec_t      next_rec,
	output logic               win,
	output sts_pkg::rec_t      rec
);
	import sts_pkg::*;

	rec_t rec_q;

	// The incoming record goes ahead of this one if this slot is empty or its
	// key pair is strictly larger; equal keys keep the earlier arrival first.
	assign win = !occupied || ({new_rec.vow, new_rec.len} > {rec_q.vow, rec_q.len});

	// On a load the cell takes its upper neighbor's record when the new one
	// landed above, takes the new one when it lands here, or holds.
	// On a drain every record moves one cell toward the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (ctrl.drain) begin
			rec_q <= next_rec;
		end else if (ctrl.load) begin
			if (prev_win) begin
				rec_q <= prev_rec;
			end else if (win) begin
				rec_q <= new_rec;
			end
		end
	end

	assign rec = rec_q;

endmodule

[hdl/stable_two_key_record_sorter.sv]
// Top level of the two-key record sorter: control and the chain of cells.
//
// Records are taken one per cycle while busy is low and are inserted into a
// chain of DEPTH cells that keeps them sorted by vowel count descending, then
// name length descending, then arrival order; the insertion finishes in the
// cycle of the transfer. After the record marked last, busy rises and the
// n stored records of the set leave the head of the chain one per cycle on
// consecutive cycles, each marked by strobe; the receiver must take every
// result in the cycle it appears. Records that arrive while DEPTH records
// are held are dropped, and every result of that set then carries overflow.
module stable_two_key_record_sorter #(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] name_length,
	input  logic [7:0] vowel_count,
	input  logic       last_record,
	output logic       strobe,
	output logic [5:0] record_index,
	output logic [7:0] out_length,
	output logic [7:0] out_vowels,
	output logic       last_out,
	output logic       overflow
);
	import sts_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t      state_q, state_d;
	logic [CW-1:0] count_q;
	logic        dropped_q;
	logic        accept;
	logic        full;
	cell_ctrl_t  ctrl;
	rec_t        new_rec;
	rec_t        cell_rec [DEPTH];
	logic        cell_win [DEPTH];
	logic        emit;

	assign accept  = start && !busy;
	assign full    = (count_q == CW'(DEPTH));
	assign new_rec = '{idx: IDX_W'(count_q), len: name_length, vow: vowel_count};

	// Next state: a last record starts the drain, the final result ends it.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && last_record) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (count_q == CW'(1)) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// State outputs.
	always_comb begin
		busy = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				busy = 1'b0;
				emit = 1'b0;
			end
			ST_EMIT: begin
				busy = 1'b1;
				emit = 1'b1;
			end
			default: begin
				busy = 1'b0;
				emit = 1'b0;
			end
		endcase
	end

	assign ctrl.load  = accept && !full;
	assign ctrl.drain = emit;

	// State, record count and drop flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				count_q <= count_q - CW'(1);
				if (count_q == CW'(1)) dropped_q <= 1'b0;
			end else if (accept) begin
				if (full) dropped_q <= 1'b1;
				else count_q <= count_q + CW'(1);
			end
		end
	end

	// The chain: each cell sees its neighbors' records and the upper win flag.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic occ;
		logic pw;
		rec_t pr;
		rec_t nr;

		assign occ = (CW'(i) < count_q);
		if (i == 0) begin : g_head
			assign pw = 1'b0;
			assign pr = new_rec;
		end else begin : g_body
			assign pw = cell_win[i-1];
			assign pr = cell_rec[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign nr = new_rec;
		end else begin : g_inner
			assign nr = cell_rec[i+1];
		end

		sts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.occupied (occ),
			.new_rec  (new_rec),
			.prev_win (pw),
			.prev_rec (pr),
			.next_rec (nr),
			.win      (cell_win[i]),
			.rec      (cell_rec[i])
		);
	end

	// Results leave from the head cell.
	assign strobe       = emit;
	assign record_index = cell_rec[0].idx;
	assign out_length   = cell_rec[0].len;
	assign out_vowels   = cell_rec[0].vow;
	assign last_out     = emit && (count_q == CW'(1));
	assign overflow     = dropped_q;

`ifndef ASSERT_OFF
	// A result is only shown while records remain in the chain.
	a_strobe_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (count_q != '0))
		else $error("result shown with an empty chain");

	// The count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count beyond chain depth");

	// A last record always starts a sorted run in the next cycle.
	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_record) |=> strobe)
		else $error("last record did not start output");

	// The final result of a run returns the block to loading with a clean set.
	a_run_ends_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_out) |=> (!busy && count_q == '0 && !dropped_q))
		else $error("run did not end cleanly");
`endif

endmodule
